// ===== sv/upd_pkg.sv =====
// Shared types, character codes and hex helpers for the percent decoder.
package upd_pkg;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Escape progress
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One classified input: one to three output bytes, last flag on the final one
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
    logic            last;
  } cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h61) begin
      v = c - 8'h57;
    end else if (c >= 8'h41) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h30;
    end
    return v[3:0];
  endfunction

endpackage

// ===== sv/upd_front.sv =====
// Front end: accepts input bytes, tracks escape state, emits byte groups.
module upd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    in_byte,
  output logic          full,
  output logic          q_wr,
  output upd_pkg::cmd_t q_wdata,
  input  logic          q_full
);
  import upd_pkg::*;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] held;
  logic       take;
  logic       c_hex;
  logic       do_fresh;
  logic [1:0] n;
  cmd_t       cmd;

  assign full  = q_full;
  assign take  = push && !q_full;
  assign c_hex = is_hex(in_byte);

  // Classify the byte against the pending escape
  always_comb begin
    cmd        = '0;
    n          = 2'd0;
    phase_next = PH_IDLE;
    do_fresh   = 1'b0;
    unique case (phase)
      PH_PCT: begin
        if (c_hex) begin
          phase_next = PH_DIGIT;
        end else begin
          cmd.bytes[0] = CH_PERCENT;
          n            = 2'd1;
          do_fresh     = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (c_hex) begin
          cmd.bytes[0] = {hex_value(held), hex_value(in_byte)};
          n            = 2'd1;
        end else begin
          cmd.bytes[0] = CH_PERCENT;
          cmd.bytes[1] = held;
          n            = 2'd2;
          do_fresh     = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase
    // Byte handled with no escape pending
    if (do_fresh) begin
      if (in_byte == CH_NUL) begin
        cmd.bytes[n] = CH_NUL;
        cmd.last     = 1'b1;
        n            = n + 2'd1;
      end else if (in_byte == CH_PERCENT) begin
        phase_next = PH_PCT;
      end else if (in_byte == CH_PLUS) begin
        cmd.bytes[n] = CH_SPACE;
        n            = n + 2'd1;
      end else begin
        cmd.bytes[n] = in_byte;
        n            = n + 2'd1;
      end
    end
    cmd.count = n;
  end

  assign q_wr    = take && (n != 2'd0);
  assign q_wdata = cmd;

  // Escape state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= 8'h00;
    end else if (take) begin
      phase <= phase_next;
      if (phase == PH_PCT && c_hex) begin
        held <= in_byte;
      end
    end
  end

endmodule

// ===== sv/upd_queue.sv =====
// Short queue of byte groups between front and back.
module upd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  upd_pkg::cmd_t wdata,
  output logic          full,
  input  logic          rd,
  output upd_pkg::cmd_t rdata,
  output logic          empty
);
  import upd_pkg::*;

  cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_AW:0]   count;
  logic                do_wr;
  logic                do_rd;

  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/upd_back.sv =====
// Back end: holds one byte group and hands its bytes out one per transaction.
module upd_back (
  input  logic          clk,
  input  logic          rst,
  input  upd_pkg::cmd_t q_rdata,
  input  logic          q_empty,
  output logic          q_rd,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          out_last
);
  import upd_pkg::*;

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       at_end;
  logic       advance;
  logic       load;

  assign at_end  = (idx == cur.count - 2'd1);
  assign advance = pop && cur_valid;
  assign load    = !q_empty && (!cur_valid || (advance && at_end));
  assign q_rd    = load;

  assign empty    = !cur_valid;
  assign out_byte = cur.bytes[idx];
  assign out_last = cur.last && at_end;

  // Current group and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (advance) begin
      if (at_end) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_rdata;
    end
  end

endmodule

// ===== sv/url_percent_decoder.sv =====
// Top level of the streaming form-urlencoded decoder.
// Input channel: drive in_byte with push high; the byte is taken at a clock
// edge where full is low. A zero byte ends the string.
// Output channel: while empty is low, out_byte/out_last show the oldest
// decoded byte; pop high at a clock edge takes it. out_last marks the zero
// terminator emitted for the end of a string.
// '%' plus two hex digits gives one byte, '+' gives a space, others pass.
// A broken escape flushes the pending '%' and digit literally, so one input
// may yield up to three output bytes.
// A result passes through the queue and then the output holding register
// before it shows on the output.
// Throughput: one input per cycle while full is low and one output per cycle
// while pop is high and empty is low; an input that yields several bytes
// drains byte by byte, absorbed by a four-entry queue between front and back.
// Reset (rst, synchronous): clears escape state and empties the queue and
// output holding register. If the receiver stops popping, the queue fills
// and full rises; no data is lost.
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import upd_pkg::*;

  logic q_wr;
  logic q_full;
  logic q_rd;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_rdata;

  upd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_byte (in_byte),
    .full    (full),
    .q_wr    (q_wr),
    .q_wdata (q_wdata),
    .q_full  (q_full)
  );

  upd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  upd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_rdata  (q_rdata),
    .q_empty  (q_empty),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule
